>>> rtl/core/sgf_pkg.sv
package sgf_pkg;

    // width of the internal position counter
    localparam int POSITION_BITS = 32;

    localparam int BASE_BITS   = 8;
    localparam int FLANK_BITS  = 16;
    localparam int RES_BITS    = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 32;

    localparam logic [FLANK_BITS-1:0] FLANK_LENGTH_RESET = 16'd100;

    localparam logic [BASE_BITS-1:0] CHAR_N_UPPER = 8'h4E;
    localparam logic [BASE_BITS-1:0] CHAR_N_LOWER = 8'h6E;

    // gap status codes
    localparam logic [STATUS_BITS-1:0] STATUS_GOOD      = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FLANK_BAD = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_AT_END    = 2'd2;

    // output tdata width, rounded up to whole bytes
    localparam int OUT_FIELD_BITS = RES_BITS + RES_BITS + STATUS_BITS + COUNT_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        MODE_OUT   = 3'b001,
        MODE_GAP   = 3'b010,
        MODE_RIGHT = 3'b100
    } scan_mode_t;

    typedef struct packed {
        logic [RES_BITS-1:0]    gap_start;
        logic [RES_BITS-1:0]    gap_end;
        logic [STATUS_BITS-1:0] gap_status;
        logic [COUNT_BITS-1:0]  gap_number;
        logic                   final_result;
    } result_t;

    // results caused by the item held in the input register
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } scan_out_t;

endpackage

>>> rtl/core/sequence_gap_flank_finder.sv
// Gap flank finder: takes the characters of sequence records, one ASCII character
// per s_ transaction, with s_tlast on the last character of each record, and reports
// every gap (a maximal run of N or n) on the m_ channel with its start position, its
// end position (first non-N after it, or the record length), a status and a running
// gap count. Status 0: both sides carry flank_length N-free bases; status 1: a flank
// is too short or holds an N; status 2: the gap runs to the end of the record.
// A gap is reported as soon as its status is known, so a report may arrive many
// characters after the gap closes. Positions restart at 0 with every record and
// saturate; the gap count runs across records. Throughput is one character per
// clock while the result queue has room: the scan state updates from the input
// register into a two-entry result queue, and a character with two reports (an N
// ending a pending right flank and closing its record) holds the input until the
// queue is empty. flank_length resets to 100; the user writes it via cfg_wr_en /
// cfg_wr_data only while the block is idle, which the block does not enforce.
module sequence_gap_flank_finder
    import sgf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    // configuration: flank_length
    input  logic                     cfg_wr_en,
    input  logic [FLANK_BITS-1:0]    cfg_wr_data,

    // character input
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [BASE_BITS-1:0]     s_tdata,   // [7:0] base
    input  logic                     s_tlast,   // record_end

    // gap reports
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // gap_start, gap_end, gap_status, gap_number
    output logic                     m_tlast    // final_result
);

    logic [FLANK_BITS-1:0] flank_length_reg;

    // input register
    logic                 in_valid_reg, in_valid_next;
    logic [BASE_BITS-1:0] base_reg;
    logic                 last_reg;

    logic       s_accept;
    logic       consume;
    logic [1:0] free_slots;
    scan_out_t  scan_out;
    result_t    out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flank_length_reg <= FLANK_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            flank_length_reg <= cfg_wr_data;
        end
    end

    // the held character moves on once the queue has room for all its reports
    assign consume  = in_valid_reg && (scan_out.count <= free_slots);
    assign s_tready = !in_valid_reg || consume;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            base_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    sgf_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (consume),
        .base         (base_reg),
        .record_end   (last_reg),
        .flank_length (flank_length_reg),
        .scan_out     (scan_out)
    );

    sgf_out_queue u_out_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (consume ? scan_out.count : 2'd0),
        .push0      (scan_out.res0),
        .push1      (scan_out.res1),
        .free_slots (free_slots),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    // pack result fields from the lowest bit up, zero fill to a whole byte
    assign m_tdata = OUT_DATA_BITS'({out_res.gap_number, out_res.gap_status,
                                     out_res.gap_end, out_res.gap_start});
    assign m_tlast = out_res.final_result;

    // a held character that cannot move on stays held
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !consume) |=> in_valid_reg)
        else $error("input character dropped while stalled");

    // the input register only refills when it is free or draining
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_valid_reg) |-> consume)
        else $error("input register overwritten");

endmodule

>>> rtl/core/sgf_scan.sv
module sgf_scan
    import sgf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  advance,
    input  logic [BASE_BITS-1:0]  base,
    input  logic                  record_end,
    input  logic [FLANK_BITS-1:0] flank_length,
    output scan_out_t             scan_out
);

    logic [POSITION_BITS-1:0] position_reg, position_next;
    logic [FLANK_BITS-1:0]    clean_run_reg, clean_run_next;
    scan_mode_t               scan_mode_reg, scan_mode_next;
    logic [POSITION_BITS-1:0] pending_start_reg, pending_start_next;
    logic [POSITION_BITS-1:0] pending_end_reg, pending_end_next;
    logic                     left_ok_reg, left_ok_next;
    logic [FLANK_BITS-1:0]    right_count_reg, right_count_next;
    logic [COUNT_BITS-1:0]    gap_total_reg, gap_total_next;

    logic                     is_gap;
    logic [POSITION_BITS-1:0] pos_plus;
    scan_mode_t               mode;
    scan_out_t                so;

    assign is_gap   = (base == CHAR_N_UPPER) || (base == CHAR_N_LOWER);
    assign pos_plus = (&position_reg) ? position_reg : position_reg + 1'b1;

    always_comb begin
        case (scan_mode_reg)
            MODE_GAP:   mode = MODE_GAP;
            MODE_RIGHT: mode = MODE_RIGHT;
            default:    mode = MODE_OUT;
        endcase
    end

    always_comb begin
        position_next      = pos_plus;
        clean_run_next     = clean_run_reg;
        scan_mode_next     = mode;
        pending_start_next = pending_start_reg;
        pending_end_next   = pending_end_reg;
        left_ok_next       = left_ok_reg;
        right_count_next   = right_count_reg;
        gap_total_next     = gap_total_reg;
        so                 = '0;

        if (is_gap) begin
            // an N ends a short right flank
            if (mode == MODE_RIGHT) begin
                so.res0.gap_start  = RES_BITS'(pending_start_reg);
                so.res0.gap_end    = RES_BITS'(pending_end_reg);
                so.res0.gap_status = STATUS_FLANK_BAD;
                so.res0.gap_number = gap_total_reg;
                so.count           = 2'd1;
            end
            if (mode != MODE_GAP) begin
                if (!(&gap_total_reg)) begin
                    gap_total_next = gap_total_reg + 1'b1;
                end
                pending_start_next = position_reg;
                left_ok_next       = clean_run_reg >= flank_length;
                scan_mode_next     = MODE_GAP;
            end
            clean_run_next = '0;
            if (record_end) begin
                if (so.count == 2'd0) begin
                    so.res0.gap_start  = RES_BITS'(pending_start_next);
                    so.res0.gap_end    = RES_BITS'(pos_plus);
                    so.res0.gap_status = STATUS_AT_END;
                    so.res0.gap_number = gap_total_next;
                end else begin
                    so.res1.gap_start  = RES_BITS'(pending_start_next);
                    so.res1.gap_end    = RES_BITS'(pos_plus);
                    so.res1.gap_status = STATUS_AT_END;
                    so.res1.gap_number = gap_total_next;
                end
                so.count = so.count + 2'd1;
            end
        end else begin
            clean_run_next = (&clean_run_reg) ? clean_run_reg : clean_run_reg + 1'b1;
            if (mode == MODE_GAP) begin
                pending_end_next = position_reg;
                right_count_next = '0;
                scan_mode_next   = MODE_RIGHT;
                if (!left_ok_reg) begin
                    so.res0.gap_start  = RES_BITS'(pending_start_reg);
                    so.res0.gap_end    = RES_BITS'(position_reg);
                    so.res0.gap_status = STATUS_FLANK_BAD;
                    so.res0.gap_number = gap_total_reg;
                    so.count           = 2'd1;
                    scan_mode_next     = MODE_OUT;
                end
            end
            if (scan_mode_next == MODE_RIGHT) begin
                right_count_next = (&right_count_next) ? right_count_next
                                                       : right_count_next + 1'b1;
                if (right_count_next >= flank_length) begin
                    so.res0.gap_start  = RES_BITS'(pending_start_reg);
                    so.res0.gap_end    = RES_BITS'(pending_end_next);
                    so.res0.gap_status = STATUS_GOOD;
                    so.res0.gap_number = gap_total_reg;
                    so.count           = 2'd1;
                    scan_mode_next     = MODE_OUT;
                end else if (record_end) begin
                    so.res0.gap_start  = RES_BITS'(pending_start_reg);
                    so.res0.gap_end    = RES_BITS'(pending_end_next);
                    so.res0.gap_status = STATUS_FLANK_BAD;
                    so.res0.gap_number = gap_total_reg;
                    so.count           = 2'd1;
                    scan_mode_next     = MODE_OUT;
                end
            end
        end

        // mark the last result of this item
        if (so.count == 2'd1) begin
            so.res0.final_result = 1'b1;
        end else if (so.count == 2'd2) begin
            so.res1.final_result = 1'b1;
        end

        // record boundary clears everything but the gap count
        if (record_end) begin
            position_next      = '0;
            clean_run_next     = '0;
            scan_mode_next     = MODE_OUT;
            pending_start_next = '0;
            pending_end_next   = '0;
            left_ok_next       = 1'b0;
            right_count_next   = '0;
        end
    end

    assign scan_out = so;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg      <= '0;
            clean_run_reg     <= '0;
            scan_mode_reg     <= MODE_OUT;
            pending_start_reg <= '0;
            pending_end_reg   <= '0;
            left_ok_reg       <= 1'b0;
            right_count_reg   <= '0;
            gap_total_reg     <= '0;
        end else if (advance) begin
            position_reg      <= position_next;
            clean_run_reg     <= clean_run_next;
            scan_mode_reg     <= scan_mode_next;
            pending_start_reg <= pending_start_next;
            pending_end_reg   <= pending_end_next;
            left_ok_reg       <= left_ok_next;
            right_count_reg   <= right_count_next;
            gap_total_reg     <= gap_total_next;
        end
    end

    // two results only come from a gap character that closes its record
    a_two_results: assert property (@(posedge aclk) disable iff (!aresetn)
        (so.count == 2'd2) |-> (is_gap && record_end))
        else $error("two results without a gap at record end");

endmodule

>>> rtl/core/sgf_out_queue.sv
module sgf_out_queue
    import sgf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_count,
    input  result_t    push0,
    input  result_t    push1,
    output logic [1:0] free_slots,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);

    localparam logic [1:0] DEPTH = 2'd2;

    result_t    slot_reg [2];
    result_t    slot_next [2];
    logic [1:0] count_reg, count_next;
    logic [1:0] count_left;
    logic       pop;

    assign pop        = (count_reg != 2'd0) && out_ready;
    assign free_slots = DEPTH - count_reg;
    assign out_valid  = count_reg != 2'd0;
    assign out_res    = slot_reg[0];

    always_comb begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        count_left   = count_reg;
        if (pop) begin
            slot_next[0] = slot_reg[1];
            count_left   = count_reg - 2'd1;
        end
        case (push_count)
            2'd1: begin
                if (count_left == 2'd0) begin
                    slot_next[0] = push0;
                end else begin
                    slot_next[1] = push0;
                end
            end
            2'd2: begin
                slot_next[0] = push0;
                slot_next[1] = push1;
            end
            default: ;
        endcase
        count_next = count_left + push_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_count != 2'd0) |-> (push_count <= free_slots))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (!pop && push_count != 2'd0) |=> (count_reg == $past(count_reg + push_count)))
        else $error("result queue count lost an entry");

endmodule
